// ===== rtl/core/apsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsc_pkg : shared types and constants for the pump and spray controller
// Word layouts, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package apsc_pkg;

	// Event codes carried in the action field
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_REFILL    = 2'd1;
	localparam logic [1:0] ACT_SPRAY_NOW = 2'd2;
	localparam logic [1:0] ACT_SPRAY_OFF = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUMP_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRIMING_TIME   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPRAY_DURATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPRAY_INTERVAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPRAY_ENABLED  = 3'd6;
	localparam int unsigned CFG_DATA_W = 12;

	// Spray status codes
	localparam logic [1:0] STAT_DISABLED = 2'd0;
	localparam logic [1:0] STAT_IDLE     = 2'd1;
	localparam logic [1:0] STAT_SPRAYING = 2'd2;

	// Elapsed-second counters saturate at all ones
	localparam int unsigned CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register reset values (timeouts held in seconds)
	localparam logic [11:0] PRESSURE_LOW_RST   = 12'd500;
	localparam logic [11:0] PRESSURE_HIGH_RST  = 12'd700;
	localparam logic [13:0] PUMP_TIMEOUT_S_RST = 14'd360;
	localparam logic [7:0]  PRIMING_TIME_RST   = 8'd10;
	localparam logic [11:0] SPRAY_DURATION_RST = 12'd10;
	localparam logic [16:0] SPRAY_INTERVAL_S_RST = 17'd900;
	localparam logic        SPRAY_ENABLED_RST  = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] pressure;
		logic        mixing;
		logic        force_spray;
	} in_word_t;

	typedef struct packed {
		logic       pump_running;
		logic       bypass_open;
		logic       spray_open;
		logic       pump_healthy;
		logic       pump_failed;
		logic [1:0] spray_status;
	} out_word_t;

	// Settings as seen by the update logic, minute limits already in seconds
	typedef struct packed {
		logic [11:0] pressure_low;
		logic [11:0] pressure_high;
		logic [13:0] pump_timeout_s;
		logic [7:0]  priming_time_s;
		logic [11:0] spray_duration_s;
		logic [16:0] spray_interval_s;
		logic        spray_enabled;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/aeroponic_pump_spray_control.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeroponic_pump_spray_control : aeroponic tank pump and spray valve control
// Event-driven pump hysteresis, self priming, timeout and spray cycling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one event word: a
//   one-second tick with pressure and mixing flag, refill, spray now or
//   spray off. Output channel (out_valid / out_stall / out_data) returns one
//   result word per event with the flags after that event.
//   A word is taken at a clock edge with valid high and stall low.
//   An input register holds the word, then the update logic writes the
//   state and the output register together. Throughput is one word per
//   cycle without receiver stalls, set by the update between the two registers.
//   When the receiver stalls, the output word holds; one more word waits in
//   the input register, after which in_stall rises.
//   Reset clears pump and bypass flags, both second counters and the pipeline;
//   the pump comes out healthy, the spray valve open, registers at defaults.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant for when no word is in flight.
// ----------------------------------------------------------------------------
module aeroponic_pump_spray_control (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire apsc_pkg::in_word_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output apsc_pkg::out_word_t                 out_data,
	input  wire logic                           cfg_we,
	input  wire logic [apsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [apsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import apsc_pkg::*;

	cfg_t      cfg;
	in_word_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      take;
	out_word_t result;
	out_word_t out_q;
	logic      out_valid_q;

	apsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Handshake: move the stage-one word on when the output slot frees up
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= in_data;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A failed pump is never reported healthy or running
	a_fail_unhealthy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.pump_failed |-> !out_q.pump_healthy && !out_q.pump_running)
		else $error("pump_failed reported with pump healthy or running");

	// Spray status agrees with the valve
	a_spray_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.spray_open == (out_q.spray_status == STAT_SPRAYING)))
		else $error("spray_status disagrees with spray_open");

	// Input is only held off while a word waits in stage one
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("in_stall raised with nothing waiting");

	// A word held in stage one is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stage-one word dropped under stall");

endmodule
`default_nettype wire

// ===== rtl/core/apsc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsc_cfg_regs : configuration register file
// Decodes register writes; minute limits are converted to seconds on write.
// ----------------------------------------------------------------------------
module apsc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [apsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [apsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output apsc_pkg::cfg_t                      cfg
);
	import apsc_pkg::*;

	cfg_t cfg_q;
	logic [13:0] timeout_s;
	logic [16:0] interval_s;

	// Scale minutes to seconds: x*60 = x*64 - x*4
	assign timeout_s  = {cfg_data[7:0], 6'd0} - {4'd0, cfg_data[7:0], 2'd0};
	assign interval_s = {cfg_data[10:0], 6'd0} - {4'd0, cfg_data[10:0], 2'd0};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_low     <= PRESSURE_LOW_RST;
			cfg_q.pressure_high    <= PRESSURE_HIGH_RST;
			cfg_q.pump_timeout_s   <= PUMP_TIMEOUT_S_RST;
			cfg_q.priming_time_s   <= PRIMING_TIME_RST;
			cfg_q.spray_duration_s <= SPRAY_DURATION_RST;
			cfg_q.spray_interval_s <= SPRAY_INTERVAL_S_RST;
			cfg_q.spray_enabled    <= SPRAY_ENABLED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESSURE_LOW:   cfg_q.pressure_low     <= cfg_data;
				REG_PRESSURE_HIGH:  cfg_q.pressure_high    <= cfg_data;
				REG_PUMP_TIMEOUT:   cfg_q.pump_timeout_s   <= timeout_s;
				REG_PRIMING_TIME:   cfg_q.priming_time_s   <= cfg_data[7:0];
				REG_SPRAY_DURATION: cfg_q.spray_duration_s <= cfg_data;
				REG_SPRAY_INTERVAL: cfg_q.spray_interval_s <= interval_s;
				REG_SPRAY_ENABLED:  cfg_q.spray_enabled    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/apsc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsc_core : controller state and single-pass update
// Holds pump, bypass, spray and health flags and both second counters, and
// works out the state and result word after one event.
// ----------------------------------------------------------------------------
module apsc_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                upd_en,
	input  wire apsc_pkg::in_word_t  item,
	input  wire apsc_pkg::cfg_t      cfg,
	output apsc_pkg::out_word_t      result
);
	import apsc_pkg::*;

	logic             pump_q, bypass_q, spray_q, ok_q;
	logic [CNT_W-1:0] pump_sec_q, spray_sec_q;

	logic             pump_d, bypass_d, spray_d, ok_d, failed_d;
	logic [CNT_W-1:0] pump_sec_d, spray_sec_d;

	// Work out the state after this event
	always_comb begin
		pump_d      = pump_q;
		bypass_d    = bypass_q;
		spray_d     = spray_q;
		ok_d        = ok_q;
		pump_sec_d  = pump_sec_q;
		spray_sec_d = spray_sec_q;
		failed_d    = 1'b0;
		case (item.action)
			ACT_TICK: begin
				// advance both counters, holding at full scale
				if (pump_sec_q != CNT_MAX)
					pump_sec_d = pump_sec_q + 1'b1;
				if (spray_sec_q != CNT_MAX)
					spray_sec_d = spray_sec_q + 1'b1;
				// pump stop and end of priming
				if (pump_q) begin
					if (item.pressure >= cfg.pressure_high) begin
						pump_d = 1'b0;
					end else begin
						if (pump_sec_d >= {3'd0, cfg.pump_timeout_s}) begin
							pump_d = 1'b0;
							if (!item.mixing) begin
								ok_d     = 1'b0;
								failed_d = 1'b1;
							end
						end
						if (!item.mixing && bypass_q &&
						    pump_sec_d >= {9'd0, cfg.priming_time_s}) begin
							bypass_d   = 1'b0;
							pump_sec_d = '0;
						end
					end
				end else begin
					bypass_d = 1'b0;
				end
				// pump start on low pressure
				if (ok_d && item.pressure <= cfg.pressure_low && !pump_d && !bypass_d) begin
					bypass_d   = 1'b1;
					pump_d     = 1'b1;
					pump_sec_d = '0;
				end
				// spray valve cycling
				if (spray_q) begin
					if (spray_sec_d >= {5'd0, cfg.spray_duration_s}) begin
						spray_d     = 1'b0;
						spray_sec_d = '0;
					end
				end else if (cfg.spray_enabled && spray_sec_d >= cfg.spray_interval_s) begin
					spray_d     = 1'b1;
					spray_sec_d = '0;
				end
			end
			ACT_REFILL: begin
				ok_d       = 1'b1;
				bypass_d   = 1'b1;
				pump_d     = 1'b1;
				pump_sec_d = '0;
			end
			ACT_SPRAY_NOW: begin
				if (cfg.spray_enabled || item.force_spray) begin
					spray_sec_d = '0;
					spray_d     = 1'b1;
				end
			end
			default: begin
				spray_d = 1'b0;
			end
		endcase
	end

	// Hold state, advance on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q      <= 1'b0;
			bypass_q    <= 1'b0;
			spray_q     <= SPRAY_ENABLED_RST;
			ok_q        <= 1'b1;
			pump_sec_q  <= '0;
			spray_sec_q <= '0;
		end else if (upd_en) begin
			pump_q      <= pump_d;
			bypass_q    <= bypass_d;
			spray_q     <= spray_d;
			ok_q        <= ok_d;
			pump_sec_q  <= pump_sec_d;
			spray_sec_q <= spray_sec_d;
		end
	end

	// Result word
	always_comb begin
		result.pump_running = pump_d;
		result.bypass_open  = bypass_d;
		result.spray_open   = spray_d;
		result.pump_healthy = ok_d;
		result.pump_failed  = failed_d;
		if (spray_d)
			result.spray_status = STAT_SPRAYING;
		else if (cfg.spray_enabled)
			result.spray_status = STAT_IDLE;
		else
			result.spray_status = STAT_DISABLED;
	end

endmodule
`default_nettype wire

// ===== tb/aeroponic_pump_spray_control_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeroponic_pump_spray_control_test : self-checking bench for the pump and
// spray valve controller
// Drives event words with random idle gaps against a randomly stalling
// receiver. A scoreboard keeps its own model of the pump, bypass and spray
// state and compares every result word, field by field, in order. The run
// covers reset defaults, zero and maximum times, crossed pressure limits
// and random settings phases with a tank pressure that follows the pump.
// ----------------------------------------------------------------------------
module aeroponic_pump_spray_control_test;
	import apsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 1500000;

	// Expected-word store with its own copy of the controller state
	class pump_spray_scoreboard;
		logic [11:0]      p_low      = 12'd500;
		logic [11:0]      p_high     = 12'd700;
		logic [7:0]       tmo_min    = 8'd6;
		logic [7:0]       prime_s    = 8'd10;
		logic [11:0]      spray_dur  = 12'd10;
		logic [10:0]      spray_ivl  = 11'd15;
		logic             spray_en   = 1'b1;
		logic             pump_on    = 1'b0;
		logic             bypass_on  = 1'b0;
		logic             spray_on   = 1'b1;
		logic             pump_ok    = 1'b1;
		logic [CNT_W-1:0] pump_secs  = '0;
		logic [CNT_W-1:0] spray_secs = '0;
		out_word_t        expected_words[$];
		int               accepted   = 0;
		int               mismatches = 0;
		int               trips      = 0;
		int               openings   = 0;

		function int pending();
			return expected_words.size();
		endfunction

		// Mirror a register write, keeping only the register's own width
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_PRESSURE_LOW:   p_low     = value;
				REG_PRESSURE_HIGH:  p_high    = value;
				REG_PUMP_TIMEOUT:   tmo_min   = value[7:0];
				REG_PRIMING_TIME:   prime_s   = value[7:0];
				REG_SPRAY_DURATION: spray_dur = value;
				REG_SPRAY_INTERVAL: spray_ivl = value[10:0];
				REG_SPRAY_ENABLED:  spray_en  = value[0];
				default: ;
			endcase
		endfunction

		// Apply one accepted event and queue the word it should produce
		function void note_event(in_word_t w);
			out_word_t r;
			logic      failed;
			logic      was_spraying;
			failed = 1'b0;
			was_spraying = spray_on;
			accepted++;
			case (w.action)
				ACT_TICK: begin
					if (pump_secs != CNT_MAX)
						pump_secs = pump_secs + 1'b1;
					if (spray_secs != CNT_MAX)
						spray_secs = spray_secs + 1'b1;
					// pump stop and priming end
					if (pump_on) begin
						if (w.pressure >= p_high) begin
							pump_on = 1'b0;
						end else begin
							if (pump_secs >= int'(tmo_min) * 60) begin
								pump_on = 1'b0;
								if (!w.mixing) begin
									pump_ok = 1'b0;
									failed = 1'b1;
								end
							end
							if (!w.mixing && bypass_on && pump_secs >= prime_s) begin
								bypass_on = 1'b0;
								pump_secs = '0;
							end
						end
					end else begin
						bypass_on = 1'b0;
					end
					// pump start with the bypass open for priming
					if (pump_ok && w.pressure <= p_low && !pump_on && !bypass_on) begin
						bypass_on = 1'b1;
						pump_on = 1'b1;
						pump_secs = '0;
					end
					// spray cycling
					if (spray_on) begin
						if (spray_secs >= spray_dur) begin
							spray_on = 1'b0;
							spray_secs = '0;
						end
					end else if (spray_en && spray_secs >= int'(spray_ivl) * 60) begin
						spray_on = 1'b1;
						spray_secs = '0;
					end
				end
				ACT_REFILL: begin
					pump_ok = 1'b1;
					bypass_on = 1'b1;
					pump_on = 1'b1;
					pump_secs = '0;
				end
				ACT_SPRAY_NOW: begin
					if (spray_en || w.force_spray) begin
						spray_secs = '0;
						spray_on = 1'b1;
					end
				end
				ACT_SPRAY_OFF: begin
					spray_on = 1'b0;
				end
			endcase
			if (failed)
				trips++;
			if (spray_on && !was_spraying)
				openings++;
			r.pump_running = pump_on;
			r.bypass_open  = bypass_on;
			r.spray_open   = spray_on;
			r.pump_healthy = pump_ok;
			r.pump_failed  = failed;
			r.spray_status = spray_on ? STAT_SPRAYING : (spray_en ? STAT_IDLE : STAT_DISABLED);
			expected_words.push_back(r);
		endfunction

		function void compare_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare a delivered word against the oldest expectation
		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				$error("result word arrived with nothing expected");
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("pump_running", want.pump_running, got.pump_running);
			compare_field("bypass_open",  want.bypass_open,  got.bypass_open);
			compare_field("spray_open",   want.spray_open,   got.spray_open);
			compare_field("pump_healthy", want.pump_healthy, got.pump_healthy);
			compare_field("pump_failed",  want.pump_failed,  got.pump_failed);
			compare_field("spray_status", want.spray_status, got.spray_status);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pump_spray_scoreboard sb = new();
	int  cycles = 0;
	int  n_writes = 0;
	int  rx_left = 0;
	int  rx_roll = 0;

	aeroponic_pump_spray_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: runs of no stall, short stalls and the odd long one
	always @(posedge clk) begin
		if (rx_left > 0) begin
			rx_left--;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 50) begin
				out_stall <= 1'b0;
				rx_left = $urandom_range(0, 20);
			end else if (rx_roll < 92) begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(8, 40);
			end
		end
	end

	// Check every word taken from the output channel
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(out_data);
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("aeroponic_pump_spray_control_test: errors");
			$finish;
		end
	end

	function automatic in_word_t ev(logic [1:0] a, logic [11:0] p, logic m, logic f);
		return '{action: a, pressure: p, mixing: m, force_spray: f};
	endfunction

	function automatic int tx_gap(bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word, hold it until taken, then idle for the given gap
	task automatic send_event(input in_word_t w, input int gap);
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_event(w);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result word
	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
		n_writes++;
	endtask

	// Write all registers; junk above a register's width must be dropped
	task automatic apply_settings(input int lo, input int hi, input int tmo,
			input int prime, input int dur, input int ivl, input int en);
		write_setting(REG_PRESSURE_LOW, 12'(lo));
		write_setting(REG_PRESSURE_HIGH, 12'(hi));
		write_setting(REG_PUMP_TIMEOUT, {4'($urandom), 8'(tmo)});
		write_setting(REG_PRIMING_TIME, {4'($urandom), 8'(prime)});
		write_setting(REG_SPRAY_DURATION, 12'(dur));
		write_setting(REG_SPRAY_INTERVAL, {1'($urandom), 11'(ivl)});
		write_setting(REG_SPRAY_ENABLED, {11'($urandom), 1'(en)});
		write_setting(REG_SPARE, 12'($urandom));
	endtask

	// One settings phase of random events; tank pressure follows the pump
	task automatic random_phase(input int n, input int mode);
		int       lo;
		int       hi;
		int       tank;
		int       roll;
		int       jump;
		int       i;
		bit       stuck;
		bit       calm;
		in_word_t w;
		lo = $urandom_range(100, 2000);
		hi = lo + $urandom_range(50, 1500);
		if (hi > 4095)
			hi = 4095;
		if ($urandom_range(0, 9) == 0) begin
			roll = lo;
			lo = hi;
			hi = roll;
		end
		case (mode)
			1: apply_settings(lo, hi, 255, 255, 3600, 1440, 1);
			2: apply_settings(lo, hi, 0, 0, 0, 0, $urandom_range(0, 1));
			default: apply_settings(lo, hi, $urandom_range(0, 2), $urandom_range(0, 20),
					$urandom_range(0, 30), $urandom_range(0, 2), $urandom_range(0, 3) != 0);
		endcase
		stuck = $urandom_range(0, 4) == 0;
		calm = $urandom_range(0, 3) == 0;
		tank = $urandom_range(0, 4095);
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				// a dead pump leaves the pressure wandering
				if (stuck)
					tank = tank + int'($urandom_range(0, 20)) - 10;
				else if (sb.pump_on)
					tank = tank + int'($urandom_range(0, 25));
				else
					tank = tank - int'($urandom_range(0, 12));
				jump = $urandom_range(0, 99);
				if (jump < 8)
					tank = $urandom_range(0, 4095);
				else if (jump < 12)
					tank = (jump % 2 == 0) ? 0 : 4095;
				if (tank < 0)
					tank = 0;
				if (tank > 4095)
					tank = 4095;
				w = ev(ACT_TICK, tank[11:0], $urandom_range(0, 6) == 0, 1'($urandom));
			end else if (roll < 88) begin
				w = ev(ACT_REFILL, 12'($urandom), 1'($urandom), 1'($urandom));
			end else if (roll < 94) begin
				w = ev(ACT_SPRAY_NOW, 12'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				w = ev(ACT_SPRAY_OFF, 12'($urandom), 1'($urandom), 1'($urandom));
			end
			if (mode == 0 && i == n / 2)
				drain_words();
			send_event(w, tx_gap(calm));
		end
		drain_words();
	endtask

	initial begin
		int k;
		int seg_mode[6] = '{0, 0, 1, 0, 2, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: spray open from reset, pump hysteresis, all events
		send_event(ev(ACT_TICK, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd4095, 1'b1, 1'b0), tx_gap(0));
		send_event(ev(ACT_SPRAY_OFF, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_SPRAY_NOW, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_REFILL, 12'd4095, 1'b1, 1'b1), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd700, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd500, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_SPRAY_OFF, 12'd4095, 1'b1, 1'b1), tx_gap(0));
		send_event(ev(ACT_TICK, 12'hAAA, 1'b1, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'h555, 1'b0, 1'b1), tx_gap(0));
		drain_words();

		// Zero times with spraying disabled: spray now needs the force bit
		apply_settings(600, 4095, 0, 0, 0, 0, 0);
		send_event(ev(ACT_SPRAY_NOW, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_SPRAY_NOW, 12'd0, 1'b0, 1'b1), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd4095, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd100, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd100, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_REFILL, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd100, 1'b1, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd100, 1'b1, 1'b0), tx_gap(0));
		drain_words();

		// Low limit above high limit, longest timeout and priming times
		apply_settings(4095, 0, 255, 255, 3600, 1440, 1);
		send_event(ev(ACT_TICK, 12'd2000, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd2000, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd0, 1'b1, 1'b0), tx_gap(0));
		send_event(ev(ACT_SPRAY_OFF, 12'd0, 1'b0, 1'b0), tx_gap(0));
		send_event(ev(ACT_TICK, 12'd4095, 1'b0, 1'b0), tx_gap(0));
		drain_words();

		// Random phases under fresh settings each time
		for (k = 0; k < 6; k++)
			random_phase(210, seg_mode[k]);

		drain_words();
		repeat (4) @(posedge clk);
		$display("Run covered %0d events and %0d register writes.", sb.accepted, n_writes);
		$display("Checked %0d pump timeout trips and %0d spray openings.", sb.trips, sb.openings);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("aeroponic_pump_spray_control_test: clean");
		else
			$display("aeroponic_pump_spray_control_test: errors");
		$finish;
	end

endmodule
